/* hdl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_tag;
endpackage
`default_nettype wire

/* hdl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: pipeline control and result register.
// Takes one beat per cycle and returns the reduced fraction of a op b for add,
// subtract, multiply or divide, sign on the numerator and the denominator as a
// magnitude; zero_den flags a zero denominator. The pipeline accepts a new beat
// in every cycle while the result register is empty or the result side takes
// beats. The pipeline consists of the decode, cross-product and signed sum
// registers, 2 * (2 * OPERAND_WIDTH + 1) binary gcd steps, one restoring division
// stage per magnitude bit, and the result register. A stall on the result side
// holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_action,
    input  wire logic [OPERAND_WIDTH-1:0]   i_num_a,
    input  wire logic [OPERAND_WIDTH-1:0]   i_den_a,
    input  wire logic [OPERAND_WIDTH-1:0]   i_num_b,
    input  wire logic [OPERAND_WIDTH-1:0]   i_den_b,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [rau_pkg::NUM_W-1:0]       o_res_num,
    output logic [rau_pkg::DEN_W-1:0]       o_res_den,
    output logic                            o_zero_den
);
    localparam int MW = 2 * OPERAND_WIDTH + 1;

    logic                      adv;
    rau_pkg::t_tag             f_tag, g_tag, d_tag;
    logic [MW-1:0]             f_num, f_den, g_num, g_den, g_gcd, d_num, d_den;
    logic [MW:0]               snum;
    logic [rau_pkg::NUM_W-1:0] n_res_num;
    logic [rau_pkg::DEN_W-1:0] n_res_den;
    logic                      r_valid;
    logic [rau_pkg::NUM_W-1:0] r_res_num;
    logic [rau_pkg::DEN_W-1:0] r_res_den;
    logic                      r_zero_den;

    assign adv        = !r_valid || i_out_ready;
    assign o_in_ready = adv;

    rau_front #(.W(OPERAND_WIDTH), .MW(MW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_in_valid),
        .i_action (rau_pkg::t_action'(i_action)),
        .i_num_a  (i_num_a),
        .i_den_a  (i_den_a),
        .i_num_b  (i_num_b),
        .i_den_b  (i_den_b),
        .o_tag    (f_tag),
        .o_num    (f_num),
        .o_den    (f_den)
    );

    rau_gcd #(.MW(MW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tag   (f_tag),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_tag   (g_tag),
        .o_num   (g_num),
        .o_den   (g_den),
        .o_gcd   (g_gcd)
    );

    rau_div #(.MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tag   (g_tag),
        .i_num   (g_num),
        .i_den   (g_den),
        .i_gcd   (g_gcd),
        .o_tag   (d_tag),
        .o_num   (d_num),
        .o_den   (d_den)
    );

    assign snum = (d_tag.neg && d_num != '0) ? (~{1'b0, d_num} + 1'b1) : {1'b0, d_num};

    if (MW + 1 >= rau_pkg::NUM_W) begin : g_num_trunc
        assign n_res_num = snum[rau_pkg::NUM_W-1:0];
    end else begin : g_num_ext
        assign n_res_num = {{(rau_pkg::NUM_W - MW - 1){snum[MW]}}, snum};
    end

    if (MW >= rau_pkg::DEN_W) begin : g_den_trunc
        assign n_res_den = d_den[rau_pkg::DEN_W-1:0];
    end else begin : g_den_ext
        assign n_res_den = {{(rau_pkg::DEN_W - MW){1'b0}}, d_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= d_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res_num  <= n_res_num;
            r_res_den  <= n_res_den;
            r_zero_den <= (d_den == '0);
        end
    end

    assign o_out_valid = r_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_zero_den  = r_zero_den;
endmodule
`default_nettype wire

/* hdl/rau_front.sv */
// Operand decode, cross products and signed sum forming the raw fraction.
`timescale 1ns / 1ps
`default_nettype none
module rau_front #(
    parameter int W  = 16,
    parameter int MW = 2 * W + 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic            i_valid,
    input  wire rau_pkg::t_action i_action,
    input  wire logic [W-1:0]    i_num_a,
    input  wire logic [W-1:0]    i_den_a,
    input  wire logic [W-1:0]    i_num_b,
    input  wire logic [W-1:0]    i_den_b,
    output rau_pkg::t_tag        o_tag,
    output logic [MW-1:0]        o_num,
    output logic [MW-1:0]        o_den
);
    logic             r_v1, r_v2, r_v3;
    rau_pkg::t_action r_act1, r_act2;
    logic             r_same1, r_same2;
    logic [W-1:0]     r_na_m, r_da_m, r_nb_m, r_db_m;
    logic             r_na_s, r_da_s, r_nb_s, r_db_s;
    logic [W-1:0]     r_na_m2, r_da_m2, r_nb_m2;
    logic             r_na_s2, r_da_s2, r_nb_s2;
    logic [2*W-1:0]   r_px, r_py, r_pz;
    logic             r_sx, r_sy, r_sz;
    logic [MW-1:0]    r_num, r_den;
    logic             r_neg;

    logic [W-1:0]     sel1_m, sel2_m;
    logic             sel1_s, sel2_s;
    logic [MW-1:0]    t1_m, t2_m, dn_m, n_num, n_den;
    logic             t1_s, t2_s, dn_s, nm_s, n_neg;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MW-1:0] ext_w(input logic [W-1:0] v);
        return {{(MW - W){1'b0}}, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        sel1_m = (r_act1 == rau_pkg::ACT_MUL) ? r_nb_m : r_db_m;
        sel1_s = (r_act1 == rau_pkg::ACT_MUL) ? r_nb_s : r_db_s;
        sel2_m = (r_act1 == rau_pkg::ACT_DIV) ? r_nb_m : r_db_m;
        sel2_s = (r_act1 == rau_pkg::ACT_DIV) ? r_nb_s : r_db_s;
    end

    always_comb begin
        if (r_same2) begin
            t1_m = ext_w(r_na_m2);
            t1_s = r_na_s2;
            t2_m = ext_w(r_nb_m2);
            t2_s = r_nb_s2;
            dn_m = ext_w(r_da_m2);
            dn_s = r_da_s2;
        end else begin
            t1_m = {1'b0, r_px};
            t1_s = r_sx;
            t2_m = {1'b0, r_py};
            t2_s = r_sy;
            dn_m = {1'b0, r_pz};
            dn_s = r_sz;
        end
        if (r_act2 == rau_pkg::ACT_SUB) begin
            t2_s = !t2_s;
        end
        if (t1_m == '0) begin
            t1_s = 1'b0;
        end
        if (t2_m == '0) begin
            t2_s = 1'b0;
        end
        if (dn_m == '0) begin
            dn_s = 1'b0;
        end
        if (r_act2 == rau_pkg::ACT_ADD || r_act2 == rau_pkg::ACT_SUB) begin
            if (t1_s == t2_s) begin
                n_num = t1_m + t2_m;
                nm_s  = t1_s;
            end else if (t1_m >= t2_m) begin
                n_num = t1_m - t2_m;
                nm_s  = t1_s;
            end else begin
                n_num = t2_m - t1_m;
                nm_s  = t2_s;
            end
        end else begin
            n_num = {1'b0, r_px};
            nm_s  = r_sx;
            dn_m  = {1'b0, r_pz};
            dn_s  = (r_pz == '0) ? 1'b0 : r_sz;
        end
        if (n_num == '0) begin
            nm_s = 1'b0;
        end
        n_den = dn_m;
        n_neg = nm_s ^ dn_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_act1  <= i_action;
            r_same1 <= (i_den_a == i_den_b);
            r_na_m  <= mag_of(i_num_a);
            r_da_m  <= mag_of(i_den_a);
            r_nb_m  <= mag_of(i_num_b);
            r_db_m  <= mag_of(i_den_b);
            r_na_s  <= i_num_a[W-1];
            r_da_s  <= i_den_a[W-1];
            r_nb_s  <= i_num_b[W-1];
            r_db_s  <= i_den_b[W-1];

            r_act2  <= r_act1;
            r_same2 <= r_same1 && (r_act1 == rau_pkg::ACT_ADD || r_act1 == rau_pkg::ACT_SUB);
            r_na_m2 <= r_na_m;
            r_da_m2 <= r_da_m;
            r_nb_m2 <= r_nb_m;
            r_na_s2 <= r_na_s;
            r_da_s2 <= r_da_s;
            r_nb_s2 <= r_nb_s;
            r_px    <= r_na_m * sel1_m;
            r_sx    <= r_na_s ^ sel1_s;
            r_py    <= r_nb_m * r_da_m;
            r_sy    <= r_nb_s ^ r_da_s;
            r_pz    <= r_da_m * sel2_m;
            r_sz    <= r_da_s ^ sel2_s;

            r_num   <= n_num;
            r_den   <= n_den;
            r_neg   <= n_neg;
        end
    end

    assign o_tag = '{valid: r_v3, neg: r_neg};
    assign o_num = r_num;
    assign o_den = r_den;
endmodule
`default_nettype wire

/* hdl/rau_gcd.sv */
// Pipelined binary greatest common divisor, one step per stage.
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd #(
    parameter int MW    = 33,
    parameter int NSTEP = 2 * MW,
    parameter int KW    = $clog2(MW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rau_pkg::t_tag i_tag,
    input  wire logic [MW-1:0] i_num,
    input  wire logic [MW-1:0] i_den,
    output rau_pkg::t_tag      o_tag,
    output logic [MW-1:0]      o_num,
    output logic [MW-1:0]      o_den,
    output logic [MW-1:0]      o_gcd
);
    rau_pkg::t_tag r_tag  [NSTEP];
    logic [MW-1:0] r_a    [NSTEP];
    logic [MW-1:0] r_b    [NSTEP];
    logic [KW-1:0] r_k    [NSTEP];
    logic          r_done [NSTEP];
    logic          r_skip [NSTEP];
    logic [MW-1:0] r_nm   [NSTEP];
    logic [MW-1:0] r_dm   [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        rau_pkg::t_tag p_tag;
        logic [MW-1:0] p_a, p_b, p_nm, p_dm, n_a, n_b;
        logic [KW-1:0] p_k, n_k;
        logic          p_done, p_skip, n_done;

        if (s == 0) begin : g_first
            assign p_tag  = i_tag;
            assign p_a    = i_num;
            assign p_b    = i_den;
            assign p_k    = '0;
            assign p_skip = (i_num == '0) || (i_den == '0);
            assign p_done = p_skip;
            assign p_nm   = i_num;
            assign p_dm   = i_den;
        end else begin : g_next
            assign p_tag  = r_tag[s-1];
            assign p_a    = r_a[s-1];
            assign p_b    = r_b[s-1];
            assign p_k    = r_k[s-1];
            assign p_skip = r_skip[s-1];
            assign p_done = r_done[s-1];
            assign p_nm   = r_nm[s-1];
            assign p_dm   = r_dm[s-1];
        end

        always_comb begin
            n_a    = p_a;
            n_b    = p_b;
            n_k    = p_k;
            n_done = p_done;
            if (!p_done) begin
                if (p_a == p_b) begin
                    n_done = 1'b1;
                end else if (!p_a[0] && !p_b[0]) begin
                    n_a = p_a >> 1;
                    n_b = p_b >> 1;
                    n_k = p_k + 1'b1;
                end else if (!p_a[0]) begin
                    n_a = p_a >> 1;
                end else if (!p_b[0]) begin
                    n_b = p_b >> 1;
                end else if (p_a > p_b) begin
                    n_a = (p_a - p_b) >> 1;
                end else begin
                    n_b = (p_b - p_a) >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s].valid <= 1'b0;
            end else if (i_adv) begin
                r_tag[s].valid <= p_tag.valid;
                r_tag[s].neg   <= p_tag.neg;
                r_a[s]         <= n_a;
                r_b[s]         <= n_b;
                r_k[s]         <= n_k;
                r_done[s]      <= n_done;
                r_skip[s]      <= p_skip;
                r_nm[s]        <= p_nm;
                r_dm[s]        <= p_dm;
            end
        end
    end

    assign o_tag = r_tag[NSTEP-1];
    assign o_num = r_nm[NSTEP-1];
    assign o_den = r_dm[NSTEP-1];
    assign o_gcd = r_skip[NSTEP-1] ? MW'(1) : (r_a[NSTEP-1] << r_k[NSTEP-1]);

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[NSTEP-1].valid |-> r_done[NSTEP-1])
        else $error("gcd steps ran out before the operands met");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[NSTEP-1].valid |-> (o_gcd != '0))
        else $error("zero divisor leaves the gcd pipeline");
endmodule
`default_nettype wire

/* hdl/rau_div.sv */
// Pipelined restoring division of numerator and denominator by their gcd.
`timescale 1ns / 1ps
`default_nettype none
module rau_div #(
    parameter int MW = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rau_pkg::t_tag i_tag,
    input  wire logic [MW-1:0] i_num,
    input  wire logic [MW-1:0] i_den,
    input  wire logic [MW-1:0] i_gcd,
    output rau_pkg::t_tag      o_tag,
    output logic [MW-1:0]      o_num,
    output logic [MW-1:0]      o_den
);
    rau_pkg::t_tag r_tag [MW];
    logic [MW-1:0] r_rn  [MW];
    logic [MW-1:0] r_qn  [MW];
    logic [MW-1:0] r_rd  [MW];
    logic [MW-1:0] r_qd  [MW];
    logic [MW-1:0] r_g   [MW];

    for (genvar s = 0; s < MW; s++) begin : g_bit
        rau_pkg::t_tag p_tag;
        logic [MW-1:0] p_rn, p_qn, p_rd, p_qd, p_g, n_rn, n_rd;
        logic [MW:0]   tn, td;
        logic          bn, bd;

        if (s == 0) begin : g_first
            assign p_tag = i_tag;
            assign p_rn  = '0;
            assign p_qn  = i_num;
            assign p_rd  = '0;
            assign p_qd  = i_den;
            assign p_g   = i_gcd;
        end else begin : g_next
            assign p_tag = r_tag[s-1];
            assign p_rn  = r_rn[s-1];
            assign p_qn  = r_qn[s-1];
            assign p_rd  = r_rd[s-1];
            assign p_qd  = r_qd[s-1];
            assign p_g   = r_g[s-1];
        end

        always_comb begin
            tn   = {p_rn, p_qn[MW-1]};
            td   = {p_rd, p_qd[MW-1]};
            bn   = (tn >= {1'b0, p_g});
            bd   = (td >= {1'b0, p_g});
            n_rn = bn ? MW'(tn - {1'b0, p_g}) : tn[MW-1:0];
            n_rd = bd ? MW'(td - {1'b0, p_g}) : td[MW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s].valid <= 1'b0;
            end else if (i_adv) begin
                r_tag[s].valid <= p_tag.valid;
                r_tag[s].neg   <= p_tag.neg;
                r_rn[s]        <= n_rn;
                r_qn[s]        <= {p_qn[MW-2:0], bn};
                r_rd[s]        <= n_rd;
                r_qd[s]        <= {p_qd[MW-2:0], bd};
                r_g[s]         <= p_g;
            end
        end
    end

    assign o_tag = r_tag[MW-1];
    assign o_num = r_qn[MW-1];
    assign o_den = r_qd[MW-1];

    a_num_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[MW-1].valid |-> (r_rn[MW-1] == '0))
        else $error("numerator is not a multiple of the gcd");
    a_den_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[MW-1].valid |-> (r_rd[MW-1] == '0))
        else $error("denominator is not a multiple of the gcd");
endmodule
`default_nettype wire

/* tb/rational_arithmetic_unit_test.sv */
// Self-checking testbench for the rational arithmetic unit with random handshake idling.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit_test;
    localparam int OW = 16;

    typedef struct {
        logic [rau_pkg::NUM_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0] den;
        logic                      zd;
    } t_fraction;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    logic [1:0]      i_action = '0;
    logic [OW-1:0]   i_num_a = '0;
    logic [OW-1:0]   i_den_a = '0;
    logic [OW-1:0]   i_num_b = '0;
    logic [OW-1:0]   i_den_b = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [rau_pkg::NUM_W-1:0] o_res_num;
    logic [rau_pkg::DEN_W-1:0] o_res_den;
    logic            o_zero_den;

    t_fraction expected_fractions[$];
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    bit idle_enable = 1'b1;
    int  op_count[4] = '{0, 0, 0, 0};

    rational_arithmetic_unit #(.OPERAND_WIDTH(OW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_num_a(i_num_a), .i_den_a(i_den_a),
        .i_num_b(i_num_b), .i_den_b(i_den_b),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_zero_den(o_zero_den)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint signed sext(logic [OW-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint unsigned gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction reduce_fraction(rau_pkg::t_action act, logic [OW-1:0] na,
                                                  logic [OW-1:0] da, logic [OW-1:0] nb,
                                                  logic [OW-1:0] db);
        longint signed a, b, c, d, n, m;
        longint unsigned nm, dm, g;
        bit neg;
        t_fraction f;
        a = sext(na); b = sext(da); c = sext(nb); d = sext(db);
        case (act)
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
                if (b == d) begin
                    n = (act == rau_pkg::ACT_SUB) ? a - c : a + c;
                    m = b;
                end else begin
                    n = (act == rau_pkg::ACT_SUB) ? a * d - c * b : a * d + c * b;
                    m = b * d;
                end
            end
            rau_pkg::ACT_MUL: begin
                n = a * c; m = b * d;
            end
            default: begin
                n = a * d; m = b * c;
            end
        endcase
        nm = (n < 0) ? -n : n;
        dm = (m < 0) ? -m : m;
        if (nm != 0 && dm != 0) begin
            g = gcd(nm, dm);
            nm /= g;
            dm /= g;
        end
        neg = ((n < 0) != (m < 0)) && nm != 0;
        f.num = neg ? rau_pkg::NUM_W'(-nm) : rau_pkg::NUM_W'(nm);
        f.den = rau_pkg::DEN_W'(dm);
        f.zd = (dm == 0);
        return f;
    endfunction

    task automatic send_beat(rau_pkg::t_action act, logic [OW-1:0] na, logic [OW-1:0] da,
                             logic [OW-1:0] nb, logic [OW-1:0] db);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_num_a <= na; i_den_a <= da; i_num_b <= nb; i_den_b <= db;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_fractions.push_back(reduce_fraction(act, na, da, nb, db));
        op_count[act]++;
        beats_sent++;
    endtask

    always @(posedge i_clk) begin
        t_fraction e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_fractions.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected: num %h den %h zd %b",
                         $time, o_res_num, o_res_den, o_zero_den);
            end else begin
                e = expected_fractions.pop_front();
                beats_checked++;
                if (o_res_num !== e.num) begin
                    errors++;
                    $display("%0t: res_num expected %h actual %h", $time, e.num, o_res_num);
                end
                if (o_res_den !== e.den) begin
                    errors++;
                    $display("%0t: res_den expected %h actual %h", $time, e.den, o_res_den);
                end
                if (o_zero_den !== e.zd) begin
                    errors++;
                    $display("%0t: zero_den expected %b actual %b", $time, e.zd, o_zero_den);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!idle_enable) begin
            i_out_ready <= 1'b1;
        end else if (i_out_ready && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
        end else if (!i_out_ready && $urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [OW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return OW'($urandom_range(0, 2)) - OW'(1);
            1: return OW'($urandom_range(0, 15)) - OW'(8);
            2: return OW'($urandom_range(0, 255)) - OW'(128);
            3: return {1'b1, {(OW-1){1'b0}}};
            default: return OW'($urandom());
        endcase
    endfunction

    task automatic test_extremes();
        logic [OW-1:0] mx, mn, z, one, m1;
        mx = {1'b0, {(OW-1){1'b1}}};
        mn = {1'b1, {(OW-1){1'b0}}};
        z = '0; one = OW'(1); m1 = '1;
        for (int a = 0; a < 4; a++) begin
            send_beat(rau_pkg::t_action'(a), mx, mx, mx, mx);
            send_beat(rau_pkg::t_action'(a), mn, mn, mn, mn);
            send_beat(rau_pkg::t_action'(a), mn, one, mx, m1);
            send_beat(rau_pkg::t_action'(a), z, OW'(3), z, OW'(5));
            send_beat(rau_pkg::t_action'(a), OW'(7), z, OW'(2), z);
        end
    endtask

    task automatic test_special_cases();
        send_beat(rau_pkg::ACT_ADD, OW'(1), OW'(6), OW'(1), OW'(3));
        send_beat(rau_pkg::ACT_SUB, OW'(1), OW'(4), OW'(1), OW'(4));
        send_beat(rau_pkg::ACT_ADD, OW'(5), OW'(-4), OW'(3), OW'(-4));
        send_beat(rau_pkg::ACT_MUL, OW'(0), OW'(0), OW'(4), OW'(9));
        send_beat(rau_pkg::ACT_DIV, OW'(6), OW'(-9), OW'(0), OW'(2));
    endtask

    task automatic test_random_mix(int n);
        logic [OW-1:0] d;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                d = rand_operand();
                send_beat(rau_pkg::t_action'($urandom_range(0, 3)), rand_operand(), d,
                          rand_operand(), d);
            end else begin
                send_beat(rau_pkg::t_action'($urandom_range(0, 3)), rand_operand(),
                          rand_operand(), rand_operand(), rand_operand());
            end
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_fractions.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_special_cases();
        test_random_mix(1500);
        idle_enable = 1'b0;
        test_random_mix(175);
        drain_results();
        $display("Checked %0d of %0d beats: add %0d, sub %0d, mul %0d, div %0d.",
                 beats_checked, beats_sent, op_count[0], op_count[1], op_count[2],
                 op_count[3]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches seen.", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d results outstanding.", expected_fractions.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
